/* design/wct_pkg.sv */
// Package for the chained table word cipher: modes, constants, issue struct, seed mix.
package wct_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 256;
    localparam int unsigned WORD_W          = 32;

    localparam logic [WORD_W-1:0] SEED_TWO_INIT = 32'hEEEE_EEEE;
    localparam logic [WORD_W-1:0] MIX_ADD       = 32'h1111_1111;
    localparam int unsigned       MIX_SHL       = 32'h15;
    localparam int unsigned       MIX_SHR       = 32'h0B;
    localparam int unsigned       SEED_TWO_SHL  = 5;
    localparam logic [WORD_W-1:0] SEED_TWO_ADD  = 32'd3;

    typedef enum logic [1:0] {
        MODE_LOAD    = 2'd0,
        MODE_ENCRYPT = 2'd1,
        MODE_DECRYPT = 2'd2,
        MODE_NONE    = 2'd3
    } t_mode;

    // word handed from the front stage to the cipher core
    typedef struct packed {
        logic              decrypt;
        logic              first;
        logic [WORD_W-1:0] seed_one;
        logic [WORD_W-1:0] data;
    } t_issue;

    // seed one remix, applied once per cipher word
    function automatic logic [WORD_W-1:0] next_seed_one(input logic [WORD_W-1:0] s);
        logic [WORD_W-1:0] inv;
        begin
            inv = ~s;
            return ((inv << MIX_SHL) + MIX_ADD) | (s >> MIX_SHR);
        end
    endfunction

endpackage

/* design/wct_table_ram.sv */
// Key table memory: one write port, one registered read port.
module wct_table_ram #(
    parameter int unsigned TABLE_DEPTH = wct_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_wr_addr,
    input  logic [wct_pkg::WORD_W-1:0]     i_wr_data,
    input  logic                           i_rd_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_rd_addr,
    output logic [wct_pkg::WORD_W-1:0]     o_rd_data
);
    import wct_pkg::*;

    logic [WORD_W-1:0] r_mem [TABLE_DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/wct_seed_front.sv */
// Front stage: decodes the input word, tracks seed one and issues table writes and reads.
module wct_seed_front #(
    parameter int unsigned TABLE_DEPTH = wct_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [1:0]                     i_mode,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_table_index,
    input  logic [wct_pkg::WORD_W-1:0]     i_data_word,
    input  logic [wct_pkg::WORD_W-1:0]     i_key_seed,
    input  logic                           i_first_word,
    input  logic                           i_advance,
    output logic                           o_wr_en,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_wr_addr,
    output logic                           o_rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_rd_addr,
    output logic                           o_issue_valid,
    output wct_pkg::t_issue                o_issue
);
    import wct_pkg::*;

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

    logic              cipher;
    logic [WORD_W-1:0] seed_now;
    logic [WORD_W-1:0] r_seed_one;
    logic              r_valid;
    t_issue            r_issue;

    // decode
    always_comb begin
        unique case (t_mode'(i_mode))
            MODE_ENCRYPT, MODE_DECRYPT: cipher = 1'b1;
            default:                    cipher = 1'b0;
        endcase
    end

    assign seed_now  = i_first_word ? i_key_seed : r_seed_one;

    // table write for load words, table read for cipher words
    assign o_wr_en   = i_accept && (t_mode'(i_mode) == MODE_LOAD);
    assign o_wr_addr = i_table_index;
    assign o_rd_en   = i_accept && cipher;
    assign o_rd_addr = seed_now[IDX_W-1:0];

    // seed one chain, independent of the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_one <= '0;
        end else if (i_accept && cipher) begin
            r_seed_one <= next_seed_one(seed_now);
        end
    end

    // issue register, waits here while the table read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept && cipher) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && cipher) begin
            r_issue.decrypt  <= (t_mode'(i_mode) == MODE_DECRYPT);
            r_issue.first    <= i_first_word;
            r_issue.seed_one <= seed_now;
            r_issue.data     <= i_data_word;
        end
    end

    assign o_issue_valid = r_valid;
    assign o_issue       = r_issue;

endmodule

/* design/wct_mix_core.sv */
// Cipher core: seed two update, result word and output register.
module wct_mix_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_issue_valid,
    input  wct_pkg::t_issue            i_issue,
    input  logic [wct_pkg::WORD_W-1:0] i_table_word,
    input  logic                       i_out_ready,
    output logic                       o_advance,
    output logic                       o_valid,
    output logic [wct_pkg::WORD_W-1:0] o_result_word
);
    import wct_pkg::*;

    logic [WORD_W-1:0] r_seed_two;
    logic [WORD_W-1:0] n_seed_two;
    logic [WORD_W-1:0] seed_base;
    logic [WORD_W-1:0] seed_mix;
    logic [WORD_W-1:0] result;
    logic [WORD_W-1:0] plain;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic              move;

    // output register free or being drained
    assign o_advance = !r_out_valid || i_out_ready;
    assign move      = i_issue_valid && o_advance;

    // one word of the chain
    always_comb begin
        seed_base  = i_issue.first ? SEED_TWO_INIT : r_seed_two;
        seed_mix   = seed_base + i_table_word;
        result     = i_issue.data ^ (i_issue.seed_one + seed_mix);
        plain      = i_issue.decrypt ? result : i_issue.data;
        n_seed_two = plain + seed_mix + (seed_mix << SEED_TWO_SHL) + SEED_TWO_ADD;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_two <= SEED_TWO_INIT;
        end else if (move) begin
            r_seed_two <= n_seed_two;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= i_issue_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_word <= result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result_word = r_out_word;

endmodule

/* design/word_chained_table_cipher.sv */
// Top level of the chained table word cipher.
//
//   channel | valid   | ready   | payload
//   --------+---------+---------+--------------------------------------------------
//   input   | i_valid | o_ready | i_mode i_table_index i_data_word i_key_seed
//           |         |         | i_first_word
//   output  | o_valid | i_ready | o_result_word
//
// One word per cycle is accepted while o_ready is high. A cipher word is taken into the
// issue register while its key table word is read, then moves on to the output register.
// Seed one and the table address run in the front stage; the seed two chain closes
// in the core. Load words write the table and give no result.
// Reset clears seed one to zero and seed two to 0xEEEEEEEE; the table is not cleared.
// A stalled output holds the core; o_ready then drops once the issue stage is full.
module word_chained_table_cipher #(
    parameter int unsigned TABLE_DEPTH = wct_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_mode,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_table_index,
    input  logic [wct_pkg::WORD_W-1:0]     i_data_word,
    input  logic [wct_pkg::WORD_W-1:0]     i_key_seed,
    input  logic                           i_first_word,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [wct_pkg::WORD_W-1:0]     o_result_word
);
    import wct_pkg::*;

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

    logic              accept;
    logic              advance;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic              issue_valid;
    t_issue            issue;

    // input handshake
    assign o_ready = !issue_valid || advance;
    assign accept  = i_valid && o_ready;

    wct_seed_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_mode        (i_mode),
        .i_table_index (i_table_index),
        .i_data_word   (i_data_word),
        .i_key_seed    (i_key_seed),
        .i_first_word  (i_first_word),
        .i_advance     (advance),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .o_issue_valid (issue_valid),
        .o_issue       (issue)
    );

    wct_table_ram #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_data_word),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    wct_mix_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_issue_valid (issue_valid),
        .i_issue       (issue),
        .i_table_word  (rd_data),
        .i_out_ready   (i_ready),
        .o_advance     (advance),
        .o_valid       (o_valid),
        .o_result_word (o_result_word)
    );

endmodule

/* design/wct_checker.sv */
// Port checker for the chained table word cipher, bound to the top level.
module wct_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_ready,
    input logic [1:0]                 i_mode,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic [wct_pkg::WORD_W-1:0] o_result_word
);
    import wct_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_word))
        else $error("result word changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a fresh result comes from a cipher word that was taken at the input
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready &&
            (i_mode == MODE_ENCRYPT || i_mode == MODE_DECRYPT), 2))
        else $error("result without a cipher word");

    // the input side never blocks while the output side drains
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready || !o_valid |-> o_ready)
        else $error("input stalled with the output free");

endmodule

bind word_chained_table_cipher wct_checker u_wct_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_mode        (i_mode),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_result_word (o_result_word)
);

/* tb/word_chained_table_cipher_tb.sv */
// Self-checking testbench for the chained table word cipher: table loads, encrypt/decrypt chains.
`timescale 1ns / 100ps

module word_chained_table_cipher_tb;
    import wct_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_WORDS   = 245;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_mode;
    logic [7:0]  i_table_index;
    logic [31:0] i_data_word;
    logic [31:0] i_key_seed;
    logic        i_first_word;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_result_word;

    // local copy of the cipher state
    logic [31:0] tab_words [TABLE_DEPTH_DEF];
    logic [31:0] chain_key;
    logic [31:0] chain_sum;
    logic [31:0] expected_words [$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int fail_count;
    int results_checked;
    int words_sent;
    int loads_sent;
    int ignored_sent;
    int cycles_run;

    word_chained_table_cipher u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_table_index (i_table_index),
        .i_data_word   (i_data_word),
        .i_key_seed    (i_key_seed),
        .i_first_word  (i_first_word),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_word (o_result_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // seed one remix: rotate in the inverted low bits, add the mix constant
    function automatic logic [31:0] remix_key(input logic [31:0] k);
        logic [31:0] hi_part;
        logic [31:0] lo_part;
        begin
            hi_part = {~k[10:0], 21'd0} + MIX_ADD;
            lo_part = {11'd0, k[31:11]};
            return hi_part | lo_part;
        end
    endfunction

    // update the local state for one accepted word, queue its result if any
    task automatic predict_word(input t_mode m, input logic [7:0] idx,
                                input logic [31:0] data, input logic [31:0] key,
                                input logic first);
        logic [31:0] res;
        logic [31:0] plain;
        case (m)
            MODE_LOAD: begin
                tab_words[idx] = data;
            end
            MODE_ENCRYPT, MODE_DECRYPT: begin
                if (first) begin
                    chain_key = key;
                    chain_sum = SEED_TWO_INIT;
                end
                chain_sum = chain_sum + tab_words[chain_key[7:0]];
                res       = data ^ (chain_key + chain_sum);
                plain     = (m == MODE_ENCRYPT) ? data : res;
                chain_key = remix_key(chain_key);
                chain_sum = plain + chain_sum + (chain_sum << SEED_TWO_SHL) + SEED_TWO_ADD;
                expected_words.push_back(res);
            end
            default: ;
        endcase
    endtask

    // offer one word, wait for the handshake; valid stays up for a back-to-back word
    task automatic send_word(input t_mode m, input logic [7:0] idx,
                             input logic [31:0] data, input logic [31:0] key,
                             input logic first);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_mode        <= m;
        i_table_index <= idx;
        i_data_word   <= data;
        i_key_seed    <= key;
        i_first_word  <= first;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_word(m, idx, data, key, first);
        case (m)
            MODE_LOAD:    loads_sent++;
            MODE_NONE:    ignored_sent++;
            default:      words_sent++;
        endcase
    endtask

    // stop offering and let every queued result come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_mode flip_dir(input t_mode m);
        return (m == MODE_ENCRYPT) ? MODE_DECRYPT : MODE_ENCRYPT;
    endfunction

    // fill every table entry; edge values at both ends
    task automatic test_table_fill();
        logic [31:0] val;
        for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
            case (i)
                0:       val = 32'h0000_0000;
                1:       val = 32'hAAAA_AAAA;
                2:       val = 32'h5555_5555;
                255:     val = 32'hFFFF_FFFF;
                default: val = $urandom;
            endcase
            send_word(MODE_LOAD, i[7:0], val, $urandom, i[0]);
        end
    endtask

    // first cipher words after reset carry no first mark: reset seeds apply
    task automatic test_reset_chain();
        send_word(MODE_ENCRYPT, 8'h00, 32'h0000_0000, $urandom, 1'b0);
        send_word(MODE_DECRYPT, 8'hFF, 32'hFFFF_FFFF, $urandom, 1'b0);
    endtask

    // field extremes, ignored items, load right before a read of the same entry
    task automatic test_directed_cases();
        logic [31:0] key;
        logic [31:0] ciphered [$];
        send_word(MODE_ENCRYPT, 8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1);
        send_word(MODE_ENCRYPT, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_word(MODE_DECRYPT, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_word(MODE_DECRYPT, 8'hFF, 32'h0000_0000, 32'h0000_0000, 1'b0);
        // unused mode with a first mark must not touch the seeds
        send_word(MODE_NONE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_word(MODE_ENCRYPT, 8'h5A, 32'hA5A5_A5A5, $urandom, 1'b0);
        // load with a first mark: seeds stay, chain continues
        send_word(MODE_LOAD, 8'h80, 32'h1234_5678, 32'hFFFF_FFFF, 1'b1);
        send_word(MODE_DECRYPT, 8'hA5, 32'h5A5A_5A5A, $urandom, 1'b0);
        // table write immediately followed by a lookup of that entry
        send_word(MODE_LOAD, 8'h80, 32'h8765_4321, 32'h0, 1'b0);
        send_word(MODE_ENCRYPT, 8'h00, $urandom, 32'h0000_0080, 1'b1);
        send_word(MODE_LOAD, 8'h80, 32'hFFFF_FFFF, 32'h0, 1'b0);
        send_word(MODE_ENCRYPT, 8'h00, $urandom, 32'hFFFF_FF80, 1'b1);
        // round trip: encrypt a block, then decrypt what came out
        key = $urandom;
        for (int i = 0; i < 4; i++) begin
            send_word(MODE_ENCRYPT, 8'($urandom), $urandom, key, i == 0);
            ciphered.push_back(expected_words[$]);
        end
        for (int i = 0; i < 4; i++)
            send_word(MODE_DECRYPT, 8'($urandom), ciphered[i], key, i == 0);
    endtask

    // random traffic: mostly keyed blocks, some loads, noise and broken chains
    task automatic run_random_traffic(input int target);
        int          start_count;
        int          pick;
        int          len;
        logic [31:0] key;
        t_mode       dir;
        t_mode       m;
        logic        first;
        logic [31:0] produced [$];
        start_count = words_sent + loads_sent;
        while (words_sent + loads_sent - start_count < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_word(MODE_NONE, 8'($urandom), $urandom, $urandom,
                          1'($urandom_range(0, 1)));
            end else if (pick < 16) begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    send_word(MODE_LOAD, 8'($urandom), $urandom, $urandom,
                              1'($urandom_range(0, 1)));
            end else if (pick < 24) begin
                // chain continues without a fresh key, either direction
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++) begin
                    m = $urandom_range(0, 1) ? MODE_DECRYPT : MODE_ENCRYPT;
                    send_word(m, 8'($urandom), $urandom, $urandom, 1'b0);
                end
            end else begin
                case ($urandom_range(0, 9))
                    0:       key = 32'h0000_0000;
                    1:       key = 32'hFFFF_FFFF;
                    default: key = $urandom;
                endcase
                dir = $urandom_range(0, 1) ? MODE_DECRYPT : MODE_ENCRYPT;
                len = $urandom_range(1, 12);
                produced.delete();
                for (int i = 0; i < len; i++) begin
                    m     = ($urandom_range(0, 9) == 0) ? flip_dir(dir) : dir;
                    first = (i == 0) || ($urandom_range(0, 19) == 0);
                    if ($urandom_range(0, 29) == 0)
                        send_word(MODE_LOAD, 8'($urandom), $urandom, $urandom, 1'b0);
                    send_word(m, 8'($urandom), $urandom, first ? key : $urandom, first);
                    produced.push_back(expected_words[$]);
                end
                // sometimes run the output back through the other direction
                if ($urandom_range(0, 9) < 3) begin
                    for (int i = 0; i < produced.size(); i++)
                        send_word(flip_dir(dir), 8'($urandom), produced[i], key, i == 0);
                end
            end
        end
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_output_hold();
        int saved_idle;
        logic [31:0] key;
        saved_idle    = send_idle_pct;
        send_idle_pct = 0;
        hold_cycles  <= HOLD_CYCLES;
        key = $urandom;
        for (int i = 0; i < 30; i++)
            send_word(i[0] ? MODE_DECRYPT : MODE_ENCRYPT, 8'($urandom), $urandom, key,
                      i == 0);
        send_idle_pct = saved_idle;
    endtask

    // result check and ready pattern
    initial begin : result_check
        logic [31:0] want;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (expected_words.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("[%0t] result_word %08h arrived with nothing expected",
                                 $time, o_result_word);
                end else begin
                    want = expected_words.pop_front();
                    results_checked++;
                    if (o_result_word !== want) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("[%0t] result_word: expected %08h, got %08h",
                                     $time, want, o_result_word);
                    end
                end
            end
            if (hold_cycles > 0) begin
                i_ready     <= 1'b0;
                hold_cycles <= hold_cycles - 1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // run limit
    initial begin : watchdog
        cycles_run = 0;
        while (cycles_run < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles_run++;
        end
        $display("Timeout after %0d cycles", cycles_run);
        $display("Mismatches found");
        $finish;
    end

    initial begin : test_sequence
        fail_count      = 0;
        results_checked = 0;
        words_sent      = 0;
        loads_sent      = 0;
        ignored_sent    = 0;
        hold_cycles     = 0;
        send_idle_pct   = 21;
        recv_idle_pct   = 61;
        chain_key       = 32'h0;
        chain_sum       = SEED_TWO_INIT;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_mode         <= MODE_NONE;
        i_table_index  <= 8'h0;
        i_data_word    <= 32'h0;
        i_key_seed     <= 32'h0;
        i_first_word   <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_fill();
        test_reset_chain();
        test_directed_cases();
        wait_drained();

        // sender idles a little, receiver a lot
        run_random_traffic(PHASE_WORDS);
        test_output_hold();
        wait_drained();

        // the other way round
        send_idle_pct = 61;
        recv_idle_pct = 21;
        run_random_traffic(PHASE_WORDS);
        wait_drained();

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_traffic(PHASE_WORDS);
        wait_drained();

        if (expected_words.size() != 0) begin
            fail_count += expected_words.size();
            $display("%0d expected results never arrived", expected_words.size());
        end
        $display("Sent %0d cipher words, %0d table loads, %0d ignored items; %0d checked",
                 words_sent, loads_sent, ignored_sent, results_checked);
        $display("Uneven idling on both sides, a %0d-cycle output hold, %0d cycles",
                 HOLD_CYCLES, cycles_run);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
